>>> src/hpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_pkg: shared types and constants of the heater PID duty controller
// Field widths, register indexes, reset values, datapath op codes, heat
// modes and the control/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package hpd_pkg;

  // Field widths
  localparam int TEMP_W     = 12;
  localparam int SP_W       = 12;
  localparam int GAIN_W     = 32;
  localparam int PERIOD_W   = 16;
  localparam int DUTY_W     = 17;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int ERR_W    = 14;               // setpoint - temperature
  localparam int MUL_B_W  = 24;               // multiplier operand chunk
  localparam int PROD_W   = GAIN_W + MUL_B_W;
  localparam int KI_MAG_W = 2 * MUL_B_W;      // integral magnitude, two chunks
  localparam int TERM_W   = 54;               // term magnitude, held at 2^53
  localparam int ACC_W    = 56;               // signed sum of the three terms

  localparam logic [TERM_W-1:0] TERM_CAP  = TERM_W'(1) << (TERM_W - 1);
  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1) << (DUTY_W - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESUME   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd7;

  // Register reset values
  localparam logic [SP_W-1:0]          RST_SETPOINT = 12'd0;
  localparam logic [GAIN_W-1:0]        RST_KP       = 32'd838861;
  localparam logic [GAIN_W-1:0]        RST_KI       = 32'd5033;
  localparam logic [GAIN_W-1:0]        RST_KD       = 32'd0;
  localparam logic signed [TEMP_W-1:0] RST_CUTOFF   = 12'sd1120;
  localparam logic signed [TEMP_W-1:0] RST_RESUME   = 12'sd960;
  localparam logic [SP_W-1:0]          RST_BOOST    = 12'd128;
  localparam logic [PERIOD_W-1:0]      RST_PERIOD   = 16'd7200;

  // Heat modes
  localparam logic [MODE_W-1:0] MODE_PID   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BOOST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd2;

  // Datapath ops
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP  = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
  localparam logic [OP_W-1:0] OP_EVAL = 4'd2;
  localparam logic [OP_W-1:0] OP_KP   = 4'd3;
  localparam logic [OP_W-1:0] OP_KD   = 4'd4;
  localparam logic [OP_W-1:0] OP_KIL  = 4'd5;
  localparam logic [OP_W-1:0] OP_KIH  = 4'd6;
  localparam logic [OP_W-1:0] OP_KIA  = 4'd7;
  localparam logic [OP_W-1:0] OP_KIS  = 4'd8;
  localparam logic [OP_W-1:0] OP_DUTY = 4'd9;
  localparam logic [OP_W-1:0] OP_CMPM = 4'd10;
  localparam logic [OP_W-1:0] OP_CMP  = 4'd11;

  // Sample classification from the evaluate step
  localparam int PATH_W = 2;
  localparam logic [PATH_W-1:0] PATH_NONE  = 2'd0;
  localparam logic [PATH_W-1:0] PATH_TRIP  = 2'd1;
  localparam logic [PATH_W-1:0] PATH_BOOST = 2'd2;
  localparam logic [PATH_W-1:0] PATH_PID   = 2'd3;

  typedef struct packed {
    logic [SP_W-1:0]          setpoint;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
    logic signed [TEMP_W-1:0] cutoff;
    logic signed [TEMP_W-1:0] resume;
    logic [SP_W-1:0]          boost;
    logic [PERIOD_W-1:0]      period;
  } hpd_cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } hpd_cmd_t;

  typedef struct packed {
    logic [PATH_W-1:0] path;
    logic              out_free;
  } hpd_sts_t;

endpackage

>>> src/hpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_if: channel interfaces of the heater PID duty controller
// Sample input, duty result and configuration write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface hpd_in_if;
  import hpd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

interface hpd_out_if;
  import hpd_pkg::*;
  logic                valid;
  logic                ready;
  logic [DUTY_W-1:0]   duty;
  logic [PERIOD_W-1:0] compare_value;
  logic [MODE_W-1:0]   heat_mode;
  modport source (output valid, output duty, output compare_value, output heat_mode,
                  input ready);
  modport sink   (input valid, input duty, input compare_value, input heat_mode,
                  output ready);
endinterface

interface hpd_cfg_if;
  import hpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/hpd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_cfg_regs: configuration register file
// Eight registers written through the configuration channel; always ready.
// ----------------------------------------------------------------------------
module hpd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output hpd_pkg::hpd_cfg_t              cfg
);
  import hpd_pkg::*;

  hpd_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint <= RST_SETPOINT;
      cfg_r.kp       <= RST_KP;
      cfg_r.ki       <= RST_KI;
      cfg_r.kd       <= RST_KD;
      cfg_r.cutoff   <= RST_CUTOFF;
      cfg_r.resume   <= RST_RESUME;
      cfg_r.boost    <= RST_BOOST;
      cfg_r.period   <= RST_PERIOD;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETPOINT: cfg_r.setpoint <= cfg_data[SP_W-1:0];
        REG_KP:       cfg_r.kp       <= cfg_data[GAIN_W-1:0];
        REG_KI:       cfg_r.ki       <= cfg_data[GAIN_W-1:0];
        REG_KD:       cfg_r.kd       <= cfg_data[GAIN_W-1:0];
        REG_CUTOFF:   cfg_r.cutoff   <= signed'(cfg_data[TEMP_W-1:0]);
        REG_RESUME:   cfg_r.resume   <= signed'(cfg_data[TEMP_W-1:0]);
        REG_BOOST:    cfg_r.boost    <= cfg_data[SP_W-1:0];
        REG_PERIOD:   cfg_r.period   <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/hpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_ctrl: sequencer of the heater PID duty controller
// Walks a sample through evaluate and the steps its path needs (multiply/
// accumulate, duty clamp, compare); one datapath op per cycle unless stalled.
// ----------------------------------------------------------------------------
module hpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output hpd_pkg::hpd_cmd_t cmd,
  input  hpd_pkg::hpd_sts_t sts
);
  import hpd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_KP   = 4'd2;
  localparam logic [3:0] S_KD   = 4'd3;
  localparam logic [3:0] S_KIL  = 4'd4;
  localparam logic [3:0] S_KIH  = 4'd5;
  localparam logic [3:0] S_KIA  = 4'd6;
  localparam logic [3:0] S_KIS  = 4'd7;
  localparam logic [3:0] S_DUTY = 4'd8;
  localparam logic [3:0] S_CMPM = 4'd9;
  localparam logic [3:0] S_CMP  = 4'd10;

  logic [3:0] state_r, state_nxt;

  // next state and op decode
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.op = OP_EVAL;
        case (sts.path)
          PATH_NONE: state_nxt = S_IDLE;
          PATH_PID:  state_nxt = S_KP;
          default:   state_nxt = S_CMP;
        endcase
      end
      S_KP: begin
        cmd.op    = OP_KP;
        state_nxt = S_KD;
      end
      S_KD: begin
        cmd.op    = OP_KD;
        state_nxt = S_KIL;
      end
      S_KIL: begin
        cmd.op    = OP_KIL;
        state_nxt = S_KIH;
      end
      S_KIH: begin
        cmd.op    = OP_KIH;
        state_nxt = S_KIA;
      end
      S_KIA: begin
        cmd.op    = OP_KIA;
        state_nxt = S_KIS;
      end
      S_KIS: begin
        cmd.op    = OP_KIS;
        state_nxt = S_DUTY;
      end
      S_DUTY: begin
        cmd.op    = OP_DUTY;
        state_nxt = S_CMPM;
      end
      S_CMPM: begin
        cmd.op    = OP_CMPM;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // hold until the output register can take the item
        if (sts.out_free) begin
          cmd.op    = OP_CMP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/hpd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_datapath: arithmetic and state of the heater PID duty controller
// Over-temperature latch, saturating integral, error history, one shared
// 32x24 multiplier, term accumulator, duty clamp and PWM compare result.
// ----------------------------------------------------------------------------
module hpd_datapath #(
  parameter int TEMP_WIDTH = 16,
  parameter int SUM_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hpd_pkg::hpd_cfg_t                   cfg,
  input  hpd_pkg::hpd_cmd_t                   cmd,
  output hpd_pkg::hpd_sts_t                   sts,
  input  logic signed [hpd_pkg::TEMP_W-1:0]   in_temperature,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hpd_pkg::DUTY_W-1:0]          out_duty,
  output logic [hpd_pkg::PERIOD_W-1:0]        out_compare_value,
  output logic [hpd_pkg::MODE_W-1:0]          out_heat_mode
);
  import hpd_pkg::*;

  // stored error width, its saturation limits and the integral limits
  localparam int LE_W   = (TEMP_WIDTH < ERR_W) ? TEMP_WIDTH : ERR_W;
  localparam int DIFF_W = LE_W + 1;
  localparam logic signed [ERR_W-1:0] LE_HI = ERR_W'((1 << (LE_W - 1)) - 1);
  localparam logic signed [ERR_W-1:0] LE_LO = ERR_W'(-(1 << (LE_W - 1)));
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  function automatic logic [ACC_W-1:0] signed_term(input logic [ACC_W-1:0] mag,
                                                   input logic neg);
    return neg ? (~mag + 1'b1) : mag;
  endfunction

  // state and working registers
  logic signed [TEMP_W-1:0]    temp_r;
  logic                        latched_r;
  logic signed [SUM_WIDTH-1:0] sum_r;
  logic signed [LE_W-1:0]      last_r, prev_r;
  logic                        err_neg_r, diff_neg_r, sum_neg_r;
  logic [ERR_W-2:0]            err_mag_r;
  logic [LE_W-1:0]             diff_mag_r;
  logic [KI_MAG_W-1:0]         ki_mag_r;
  logic [PROD_W-1:0]           prod_r;
  logic [TERM_W-1:0]           tmag_r, tmag_nxt;
  logic signed [ACC_W-1:0]     acc_r;
  logic [DUTY_W-1:0]           duty_r;
  logic [MODE_W-1:0]           mode_r;
  logic                        out_valid_r;
  logic [DUTY_W-1:0]           out_duty_r;
  logic [PERIOD_W-1:0]         out_cmp_r;
  logic [MODE_W-1:0]           out_mode_r;

  // evaluate-step signals
  logic                        trip, release_hit, latched_eval;
  logic signed [ERR_W-1:0]     err, err_le;
  logic [ERR_W-1:0]            err_abs;
  logic signed [DIFF_W-1:0]    diff;
  logic [DIFF_W-1:0]           diff_abs;
  logic signed [SUM_WIDTH-1:0] sum_base, sum_sat;
  logic [SUM_WIDTH:0]          sum_wide;
  logic [SUM_WIDTH-1:0]        sum_abs;
  logic [PATH_W-1:0]           path;

  // multiplier and compare signals
  logic [GAIN_W-1:0]           mul_a;
  logic [MUL_B_W-1:0]          mul_b;
  logic [PROD_W-1:0]           mul_p;
  logic [TERM_W:0]             ki_sum;
  logic                        ki_hi_big;
  logic [PERIOD_W-1:0]         cmp_val;

  // classify the sample, latch, integral and error history
  always_comb begin
    trip         = temp_r > cfg.cutoff;
    release_hit  = temp_r < cfg.resume;
    latched_eval = release_hit ? 1'b0 : (trip | latched_r);
    err          = $signed({2'b00, cfg.setpoint}) - {{(ERR_W-TEMP_W){temp_r[TEMP_W-1]}}, temp_r};
    err_abs      = err[ERR_W-1] ? (~err + 1'b1) : err;
    sum_base     = trip ? '0 : sum_r;
    sum_wide     = {sum_base[SUM_WIDTH-1], sum_base}
                 + {{(SUM_WIDTH+1-ERR_W){err[ERR_W-1]}}, err};
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
    if (err > LE_HI) begin
      err_le = LE_HI;
    end else if (err < LE_LO) begin
      err_le = LE_LO;
    end else begin
      err_le = err;
    end
    diff     = {last_r[LE_W-1], last_r} - {prev_r[LE_W-1], prev_r};
    diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    sum_abs  = sum_r[SUM_WIDTH-1] ? (~sum_r + 1'b1) : sum_r;
    if (latched_eval) begin
      path = trip ? PATH_TRIP : PATH_NONE;
    end else if (err > $signed({2'b00, cfg.boost})) begin
      path = PATH_BOOST;
    end else begin
      path = PATH_PID;
    end
  end

  assign sts.path     = path;
  assign sts.out_free = !out_valid_r || out_ready;

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_KP: begin
        mul_a = cfg.kp;
        mul_b = MUL_B_W'(err_mag_r);
      end
      OP_KD: begin
        mul_a = cfg.kd;
        mul_b = MUL_B_W'(diff_mag_r);
      end
      OP_KIL: begin
        mul_a = cfg.ki;
        mul_b = ki_mag_r[MUL_B_W-1:0];
      end
      OP_KIH: begin
        mul_a = cfg.ki;
        mul_b = ki_mag_r[KI_MAG_W-1:MUL_B_W];
      end
      OP_CMPM: begin
        mul_a = GAIN_W'(cfg.period);
        mul_b = MUL_B_W'(duty_r[DUTY_W-2:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // integral term magnitude, held at the cap
  always_comb begin
    ki_hi_big = |prod_r[PROD_W-1:TERM_W-1-MUL_B_W];
    ki_sum    = {1'b0, tmag_r}
              + (TERM_W+1)'({prod_r[TERM_W-2-MUL_B_W:0], {MUL_B_W{1'b0}}});
    case (cmd.op)
      OP_KIH:  tmag_nxt = (prod_r >= PROD_W'(TERM_CAP)) ? TERM_CAP : prod_r[TERM_W-1:0];
      OP_KIA:  tmag_nxt = (ki_hi_big || ki_sum >= (TERM_W+1)'(TERM_CAP)) ? TERM_CAP
                                                                      : ki_sum[TERM_W-1:0];
      default: tmag_nxt = tmag_r;
    endcase
  end

  // PWM compare from the final duty
  always_comb begin
    if (duty_r == '0) begin
      cmp_val = cfg.period;
    end else if (duty_r[DUTY_W-1]) begin
      cmp_val = '0;
    end else if (cfg.period == '0) begin
      cmp_val = '0;
    end else begin
      cmp_val = cfg.period - 1'b1 - prod_r[2*PERIOD_W-1:PERIOD_W];
    end
  end

  // control state: latch, integral, error history, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r   <= 1'b0;
      sum_r       <= '0;
      last_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_EVAL) begin
        latched_r <= latched_eval;
        sum_r     <= (path == PATH_PID) ? sum_sat : sum_base;
        if (path == PATH_PID) begin
          prev_r <= last_r;
          last_r <= err_le[LE_W-1:0];
        end
      end
      if (cmd.op == OP_CMP) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tmag_r <= tmag_nxt;
    case (cmd.op)
      OP_LOAD: temp_r <= in_temperature;
      OP_EVAL: begin
        err_neg_r  <= err[ERR_W-1];
        err_mag_r  <= err_abs[ERR_W-2:0];
        diff_neg_r <= diff[DIFF_W-1];
        diff_mag_r <= diff_abs[LE_W-1:0];
        if (path == PATH_TRIP) begin
          duty_r <= '0;
          mode_r <= MODE_OFF;
        end else begin
          duty_r <= DUTY_FULL;
          mode_r <= MODE_BOOST;
        end
      end
      OP_KP: begin
        prod_r    <= mul_p;
        sum_neg_r <= sum_r[SUM_WIDTH-1];
        ki_mag_r  <= KI_MAG_W'(sum_abs);
      end
      OP_KD: begin
        prod_r <= mul_p;
        acc_r  <= signed_term(ACC_W'(prod_r), err_neg_r);
      end
      OP_KIL: begin
        prod_r <= mul_p;
        acc_r  <= acc_r + signed_term(ACC_W'(prod_r), diff_neg_r);
      end
      OP_KIH:  prod_r <= mul_p;
      OP_KIS:  acc_r  <= acc_r + signed_term(ACC_W'(tmag_r), sum_neg_r);
      OP_DUTY: begin
        mode_r <= MODE_PID;
        if (acc_r[ACC_W-1] || acc_r == '0) begin
          duty_r <= '0;
        end else if (|acc_r[ACC_W-2:24]) begin
          duty_r <= DUTY_FULL;
        end else begin
          duty_r <= {1'b0, acc_r[23:8]};
        end
      end
      OP_CMPM: prod_r <= mul_p;
      OP_CMP: begin
        out_duty_r <= duty_r;
        out_cmp_r  <= cmp_val;
        out_mode_r <= mode_r;
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_duty          = out_duty_r;
  assign out_compare_value = out_cmp_r;
  assign out_heat_mode     = out_mode_r;

endmodule

>>> src/heater_pid_duty_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_pid_duty_controller: heater duty from temperature samples
// Over-temperature latch, boost, and positional PID on 8.24 gains, giving a
// 1.16 duty, a PWM compare value and the heat mode.
//
//   channel | port   | direction | moves
//   --------+--------+-----------+-----------------------------------------
//   input   | in_ch  | sink      | one temperature sample per item
//   result  | out_ch | source    | duty, compare_value, heat_mode per item
//   config  | cfg_ch | sink      | register index and write data
//
// One item at a time. A PID item runs evaluate, four passes through the one
// 32x24 multiplier with accumulate, two integral saturation steps, duty
// clamp, compare multiply and compare, which loads the output register.
// Trip and boost items go from evaluate straight to compare; a latched
// sample with no result ends after evaluate. The next item is taken the
// cycle after its last step. Synchronous active-low reset, no clearing
// pass. The compare step waits while the output register is full.
// ----------------------------------------------------------------------------
module heater_pid_duty_controller #(
  parameter int TEMP_WIDTH = 16,
  parameter int SUM_WIDTH  = 32
) (
  input logic       clk,
  input logic       rst_n,
  hpd_in_if.sink    in_ch,
  hpd_out_if.source out_ch,
  hpd_cfg_if.sink   cfg_ch
);
  import hpd_pkg::*;

  hpd_cfg_t cfg;
  hpd_cmd_t cmd;
  hpd_sts_t sts;

  hpd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cfg       (cfg)
  );

  hpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  hpd_datapath #(
    .TEMP_WIDTH (TEMP_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .sts               (sts),
    .in_temperature    (in_ch.temperature),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_duty          (out_ch.duty),
    .out_compare_value (out_ch.compare_value),
    .out_heat_mode     (out_ch.heat_mode)
  );

endmodule

>>> src/hpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_checker: port-level assertions of the heater PID duty controller
// Checks result hold under stall, one item in flight, and mode/duty pairing.
// ----------------------------------------------------------------------------
module hpd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [hpd_pkg::DUTY_W-1:0]       out_duty,
  input logic [hpd_pkg::PERIOD_W-1:0]     out_compare_value,
  input logic [hpd_pkg::MODE_W-1:0]       out_heat_mode
);
  import hpd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty)
      && $stable(out_compare_value) && $stable(out_heat_mode))
    else $error("result changed while stalled");

  // an accepted item closes the input right after acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // over-temperature gives zero duty
  a_off_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heat_mode == MODE_OFF |-> out_duty == '0)
    else $error("off mode with nonzero duty");

  // boost gives full duty and zero compare
  a_boost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heat_mode == MODE_BOOST |-> out_duty == DUTY_FULL
      && out_compare_value == '0)
    else $error("boost mode without full duty");

  // full duty maps to zero compare, and duty never exceeds full
  a_full_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty <= DUTY_FULL
      && (out_duty != DUTY_FULL || out_compare_value == '0))
    else $error("duty out of range or full duty with nonzero compare");

endmodule

bind heater_pid_duty_controller hpd_checker u_hpd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_duty          (out_ch.duty),
  .out_compare_value (out_ch.compare_value),
  .out_heat_mode     (out_ch.heat_mode)
);
